// ----- rtl/core/tspa_pkg.sv -----
package tspa_pkg;

  localparam int PACKET_LEN_DEF    = 188;
  localparam int CHECK_PACKETS_DEF = 4;
  localparam int QUEUE_DEPTH       = 2;

  localparam int BYTE_W   = 8;
  localparam int THRESH_W = 4;
  localparam int STREAK_W = 4;
  localparam int SKIP_W   = 16;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [BYTE_W-1:0]   SYNC_RESET   = 8'h47;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 4'd3;
  localparam logic [STREAK_W-1:0] STREAK_MAX   = 4'hF;
  localparam logic [SKIP_W-1:0]   SKIP_MAX     = 16'hFFFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SYNC_VALUE     = 1'b0,
    CFG_LOCK_THRESHOLD = 1'b1
  } cfg_reg_t;

  // One classified result on its way from the front to the output stage.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
    logic [SKIP_W-1:0] skipped;
  } tspa_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tspa_q_status_t;

endpackage

// ----- rtl/core/tspa_if.sv -----
interface tspa_in_if;
  import tspa_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface tspa_out_if;
  import tspa_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              packet_first;
  logic              packet_last;
  logic [SKIP_W-1:0] skipped_count;

  modport source (output valid, output out_byte, output packet_first, output packet_last,
                  output skipped_count, input ready);
  modport sink (input valid, input out_byte, input packet_first, input packet_last,
                input skipped_count, output ready);
endinterface

// ----- rtl/core/tspa_front.sv -----
module tspa_front #(
  parameter int PACKET_LEN    = tspa_pkg::PACKET_LEN_DEF,
  parameter int CHECK_PACKETS = tspa_pkg::CHECK_PACKETS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  tspa_in_if.sink                          byte_in,
  input  logic                             cfg_we,
  input  logic [tspa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tspa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  tspa_pkg::tspa_q_status_t         q_status,
  output logic                             push,
  output tspa_pkg::tspa_item_t             push_item
);
  import tspa_pkg::*;

  localparam int WIN    = PACKET_LEN * CHECK_PACKETS;
  localparam int PTR_W  = $clog2(PACKET_LEN);
  localparam int FILL_W = $clog2(WIN + 1);

  logic [BYTE_W-1:0]   sync_value;
  logic [THRESH_W-1:0] lock_threshold;

  logic [PTR_W-1:0]    ptr;
  logic [PTR_W-1:0]    ptr_next;
  logic [FILL_W-1:0]   fill;
  logic [PTR_W-1:0]    phase;
  logic [PTR_W-1:0]    phase_next;
  logic [STREAK_W-1:0] streak;
  logic [STREAK_W-1:0] streak_next;
  logic [SKIP_W-1:0]   dropped;
  logic [SKIP_W-1:0]   dropped_next;

  // Head byte of each packet-length segment of the window, i.e. window offset k * PACKET_LEN.
  logic [BYTE_W-1:0]        tap [CHECK_PACKETS];
  logic [BYTE_W-1:0]        seg_in [CHECK_PACKETS];
  logic [CHECK_PACKETS-1:0] tap_match;

  logic accept;
  logic full;
  logic start_ok;

  assign byte_in.ready = !q_status.full;
  assign accept        = byte_in.valid && byte_in.ready;
  assign full          = (fill == FILL_W'(WIN));
  assign ptr_next      = (ptr == PTR_W'(PACKET_LEN - 1)) ? '0 : ptr + 1'b1;

  // The window is a chain of segment delay lines that all advance on every transaction.
  for (genvar k = 0; k < CHECK_PACKETS; k++) begin : g_seg
    logic [BYTE_W-1:0] seg_mem [PACKET_LEN];

    if (k == CHECK_PACKETS - 1) begin : g_last
      assign seg_in[k] = byte_in.data_byte;
    end else begin : g_mid
      assign seg_in[k] = tap[k+1];
    end

    assign tap_match[k] = (tap[k] == sync_value);

    always_ff @(posedge clk) begin
      if (accept) begin
        seg_mem[ptr] <= seg_in[k];
        tap[k]       <= seg_mem[ptr_next];
      end
    end
  end

  assign start_ok = ((streak >= lock_threshold) && tap_match[0]) || (&tap_match);

  always_comb begin
    push              = 1'b0;
    push_item.data    = tap[0];
    push_item.first   = 1'b0;
    push_item.last    = 1'b0;
    push_item.skipped = '0;
    phase_next        = phase;
    streak_next       = streak;
    dropped_next      = dropped;
    priority if (phase != '0) begin
      push           = accept;
      push_item.last = (phase == PTR_W'(PACKET_LEN - 1));
      phase_next     = push_item.last ? '0 : phase + 1'b1;
    end else if (full && start_ok) begin
      push              = accept;
      push_item.first   = 1'b1;
      push_item.skipped = dropped;
      phase_next        = PTR_W'(1);
      dropped_next      = '0;
      streak_next       = (streak == STREAK_MAX) ? streak : streak + 1'b1;
    end else if (full) begin
      streak_next  = '0;
      dropped_next = (dropped == SKIP_MAX) ? dropped : dropped + 1'b1;
    end else begin
      phase_next = phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      fill    <= '0;
      phase   <= '0;
      streak  <= '0;
      dropped <= '0;
    end else if (accept) begin
      ptr     <= ptr_next;
      fill    <= full ? fill : fill + 1'b1;
      phase   <= phase_next;
      streak  <= streak_next;
      dropped <= dropped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value     <= SYNC_RESET;
      lock_threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SYNC_VALUE:     sync_value     <= cfg_data[BYTE_W-1:0];
        CFG_LOCK_THRESHOLD: lock_threshold <= cfg_data[THRESH_W-1:0];
      endcase
    end
  end

`ifndef SYNTHESIS
  a_phase_needs_full: assert property (@(posedge clk) disable iff (rst)
    phase != '0 |-> full)
    else $error("packet in progress with window not full");

  a_body_always_pushes: assert property (@(posedge clk) disable iff (rst)
    (accept && phase != '0) |-> push)
    else $error("packet body transaction produced no result");

  a_first_starts_body: assert property (@(posedge clk) disable iff (rst)
    (push && push_item.first) |=> (phase == PTR_W'(1)))
    else $error("packet start did not begin the packet body");
`endif

endmodule

// ----- rtl/core/tspa_queue.sv -----
module tspa_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  tspa_pkg::tspa_item_t     push_item,
  input  logic                     pop,
  output tspa_pkg::tspa_item_t     pop_item,
  output tspa_pkg::tspa_q_status_t status
);
  import tspa_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tspa_item_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_item     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (status.full && push) |-> pop)
    else $error("result queue overrun");
`endif

endmodule

// ----- rtl/core/tspa_back.sv -----
module tspa_back (
  input  logic                     clk,
  input  logic                     rst,
  input  tspa_pkg::tspa_q_status_t q_status,
  input  tspa_pkg::tspa_item_t     q_item,
  output logic                     pop,
  tspa_out_if.source               pkt_out
);
  import tspa_pkg::*;

  logic valid;

  assign pop           = !q_status.empty && (!valid || pkt_out.ready);
  assign pkt_out.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop) begin
      valid <= 1'b1;
    end else if (pkt_out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pkt_out.out_byte      <= q_item.data;
      pkt_out.packet_first  <= q_item.first;
      pkt_out.packet_last   <= q_item.last;
      pkt_out.skipped_count <= q_item.skipped;
    end
  end

`ifndef SYNTHESIS
  a_skip_only_on_first: assert property (@(posedge clk) disable iff (rst)
    (pkt_out.valid && !pkt_out.packet_first) |-> (pkt_out.skipped_count == '0))
    else $error("skip count on a byte that does not start a packet");
`endif

endmodule

// ----- rtl/core/ts_packet_sync_aligner.sv -----
// Latency: a result goes through the result queue and the output registers before it is offered;
// packet bytes leave the window PACKET_LEN * CHECK_PACKETS input transactions after they entered.
// Throughput: one input byte per cycle, sustained while the result queue is not full; each window
// segment memory does one write and one read per cycle, which sets that figure.
// Reset: synchronous; clears the fill count, packet phase, streak, skip count and queue,
// and restores both configuration registers. Window memory is not cleared.
module ts_packet_sync_aligner #(
  parameter int PACKET_LEN    = tspa_pkg::PACKET_LEN_DEF,
  parameter int CHECK_PACKETS = tspa_pkg::CHECK_PACKETS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  tspa_in_if.sink                          byte_in,
  tspa_out_if.source                       pkt_out,
  input  logic                             cfg_we,
  input  logic [tspa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tspa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tspa_pkg::*;

  logic           push;
  logic           pop;
  tspa_item_t     push_item;
  tspa_item_t     pop_item;
  tspa_q_status_t q_status;

  tspa_front #(
    .PACKET_LEN    (PACKET_LEN),
    .CHECK_PACKETS (CHECK_PACKETS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  tspa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  tspa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_item   (pop_item),
    .pop      (pop),
    .pkt_out  (pkt_out)
  );

endmodule

// ----- dv/tspa_alignment_checker.sv -----
`timescale 1ns / 100ps

module tspa_alignment_checker #(
  parameter int PACKET_LEN    = tspa_pkg::PACKET_LEN_DEF,
  parameter int CHECK_PACKETS = tspa_pkg::CHECK_PACKETS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  tspa_in_if                               byte_in,
  tspa_out_if                              pkt_out,
  input  logic                             cfg_we,
  input  logic [tspa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tspa_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               n_pending,
  output int                               n_failed
);
  import tspa_pkg::*;

  localparam int WIN_BYTES = PACKET_LEN * CHECK_PACKETS;

  // Shadow copy of the lookahead window and the alignment state.
  logic [BYTE_W-1:0]   win_mem [WIN_BYTES];
  int unsigned         win_fill;
  int unsigned         win_head;
  int unsigned         pkt_phase;
  logic [STREAK_W-1:0] streak;
  logic [SKIP_W-1:0]   dropped;
  logic [BYTE_W-1:0]   sync_v;
  logic [THRESH_W-1:0] thresh;

  tspa_item_t pending_pkt_bytes [$];
  int         errors = 0;

  function automatic logic [BYTE_W-1:0] take_head();
    logic [BYTE_W-1:0] b;
    b = win_mem[win_head];
    win_head = (win_head + 1) % WIN_BYTES;
    if (win_fill > 0) win_fill--;
    return b;
  endfunction

  // When locked, a sync byte at the head is enough; otherwise every packet
  // offset in the window must carry one.
  function automatic bit head_is_packet_start();
    int i;
    bit ok;
    ok = 1'b1;
    if (streak >= thresh && win_mem[win_head] == sync_v) return 1'b1;
    for (i = 0; i < CHECK_PACKETS; i++) begin
      if (win_mem[(win_head + i * PACKET_LEN) % WIN_BYTES] != sync_v) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic void advance_window(input logic [BYTE_W-1:0] din);
    tspa_item_t r;
    r = '0;
    if (pkt_phase > 0) begin
      r.data = take_head();
      r.last = (pkt_phase >= PACKET_LEN - 1);
      pkt_phase = r.last ? 0 : pkt_phase + 1;
      pending_pkt_bytes.push_back(r);
    end else if (win_fill >= WIN_BYTES) begin
      if (head_is_packet_start()) begin
        if (streak != STREAK_MAX) streak++;
        r.data    = take_head();
        r.first   = 1'b1;
        r.skipped = dropped;
        dropped   = '0;
        pkt_phase = 1;
        pending_pkt_bytes.push_back(r);
      end else begin
        void'(take_head());
        streak = '0;
        if (dropped != SKIP_MAX) dropped++;
      end
    end
    if (win_fill < WIN_BYTES) begin
      win_mem[(win_head + win_fill) % WIN_BYTES] = din;
      win_fill++;
    end
  endfunction

  always @(posedge clk) begin : watch
    tspa_item_t want;
    if (rst) begin
      win_fill  = 0;
      win_head  = 0;
      pkt_phase = 0;
      streak    = '0;
      dropped   = '0;
      sync_v    = SYNC_RESET;
      thresh    = THRESH_RESET;
      pending_pkt_bytes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SYNC_VALUE:     sync_v = cfg_data[BYTE_W-1:0];
          CFG_LOCK_THRESHOLD: thresh = cfg_data[THRESH_W-1:0];
          default: ;
        endcase
      end
      if (byte_in.valid && byte_in.ready) advance_window(byte_in.data_byte);
      if (pkt_out.valid && pkt_out.ready) begin
        if (pending_pkt_bytes.size() == 0) begin
          $error("unexpected output transaction: out_byte %h first %b last %b skipped %0d",
                 pkt_out.out_byte, pkt_out.packet_first, pkt_out.packet_last,
                 pkt_out.skipped_count);
          errors++;
        end else begin
          want = pending_pkt_bytes[0];
          pending_pkt_bytes.delete(0);
          if (pkt_out.out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, pkt_out.out_byte);
            errors++;
          end
          if (pkt_out.packet_first !== want.first) begin
            $error("packet_first: expected %b, got %b", want.first, pkt_out.packet_first);
            errors++;
          end
          if (pkt_out.packet_last !== want.last) begin
            $error("packet_last: expected %b, got %b", want.last, pkt_out.packet_last);
            errors++;
          end
          if (pkt_out.skipped_count !== want.skipped) begin
            $error("skipped_count: expected %0d, got %0d", want.skipped,
                   pkt_out.skipped_count);
            errors++;
          end
        end
      end
    end
    n_pending <= pending_pkt_bytes.size();
    n_failed  <= errors;
  end

endmodule

// ----- dv/ts_packet_sync_aligner_tb.sv -----
`timescale 1ns / 100ps

module ts_packet_sync_aligner_tb;
  import tspa_pkg::*;

  localparam int PACKET_LEN    = PACKET_LEN_DEF;
  localparam int N_SETTINGS    = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_AFTER    = 150;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 3000;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  tspa_in_if  byte_ch ();
  tspa_out_if pkt_ch ();

  int n_pending;
  int n_failed;
  int n_sent = 0;
  int n_out = 0;
  int n_pkts = 0;
  int quiet = 0;
  int tx_idle_pct = 9;
  int rx_idle_pct = 64;

  // Stream generator state: position inside the current packet and its sync byte.
  int                stream_pos = 0;
  logic [BYTE_W-1:0] stream_sync = SYNC_RESET;

  // Three stray bytes, then a packet that opens with extreme content values.
  logic [BYTE_W-1:0] lead_bytes [12] = '{8'h00, 8'hFF, 8'h47, SYNC_RESET, 8'h00, 8'hFF,
                                         8'h55, 8'hAA, 8'h80, 8'h7F, 8'h01, 8'hFE};
  logic [BYTE_W-1:0]   set_sync [N_SETTINGS] = '{8'h47, 8'h47, 8'h00, 8'h00, 8'hFF};
  logic [THRESH_W-1:0] set_thr  [N_SETTINGS] = '{4'd3, 4'd15, 4'd1, 4'd0, 4'd2};
  int                  set_len  [N_SETTINGS] = '{900, 150, 500, 150, 138};

  always #6 clk = ~clk;

  ts_packet_sync_aligner dut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_ch),
    .pkt_out   (pkt_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tspa_alignment_checker chk (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_ch),
    .pkt_out   (pkt_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .n_pending (n_pending),
    .n_failed  (n_failed)
  );

  // Mostly well-formed packets with random content; now and then a corrupted
  // sync byte or a stray byte that shifts the packet grid.
  function automatic logic [BYTE_W-1:0] next_stream_byte();
    logic [BYTE_W-1:0] b;
    int roll;
    roll = $urandom_range(9999);
    if (roll < 10) begin
      b = BYTE_W'($urandom);
    end else begin
      if (stream_pos == 0) begin
        b = (roll < 300) ? ~stream_sync : stream_sync;
      end else begin
        case (roll % 10)
          0: b = 8'h00;
          1: b = 8'hFF;
          2: b = stream_sync;
          default: b = BYTE_W'($urandom);
        endcase
      end
      stream_pos = (stream_pos + 1) % PACKET_LEN;
    end
    return b;
  endfunction

  // Called and returns at a falling edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_cfg(input logic [BYTE_W-1:0] sync, input logic [THRESH_W-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC_VALUE;
    cfg_data  <= CFG_DATA_W'(sync);
    @(negedge clk);
    cfg_index <= CFG_LOCK_THRESHOLD;
    cfg_data  <= CFG_DATA_W'(thr);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int s;
    int k;
    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_SYNC_VALUE;
    cfg_data          = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (lead_bytes[k]) send_byte(lead_bytes[k]);
    stream_pos = 9;

    for (s = 0; s < N_SETTINGS; s++) begin
      // The first setting runs on the reset values of both registers.
      if (s > 0) begin
        wait_drained();
        program_cfg(set_sync[s], set_thr[s]);
      end
      stream_sync = set_sync[s];
      if (s < 2) begin
        tx_idle_pct = 9;
        rx_idle_pct = 64;
      end else if (s == 2) begin
        tx_idle_pct = 64;
        rx_idle_pct = 9;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (k = 0; k < set_len[s]; k++) begin
        if (s == 0 && k == 850) wait_drained();
        send_byte(next_stream_byte());
      end
    end

    wait_drained();
    $display("Run covered %0d stream bytes over %0d sync/threshold settings,", n_sent,
             N_SETTINGS);
    $display("with %0d aligned bytes in %0d packets checked against the prediction.",
             n_out, n_pkts);
    if (n_failed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver side: random stalls, plus one long hold-off that backs up the block.
  initial begin : receiver
    int hold_left;
    bit held;
    hold_left    = 0;
    held         = 1'b0;
    pkt_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && n_out >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pkt_ch.ready <= 1'b0;
      end else begin
        pkt_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else begin
      if (pkt_ch.valid && pkt_ch.ready) begin
        n_out <= n_out + 1;
        if (pkt_ch.packet_first) n_pkts <= n_pkts + 1;
      end
      if ((byte_ch.valid && byte_ch.ready) || (pkt_ch.valid && pkt_ch.ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding.",
                 quiet, n_pending);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

endmodule

// ----- filelist.f -----
rtl/core/tspa_pkg.sv
rtl/core/tspa_if.sv
rtl/core/tspa_front.sv
rtl/core/tspa_queue.sv
rtl/core/tspa_back.sv
rtl/core/ts_packet_sync_aligner.sv
dv/tspa_alignment_checker.sv
dv/ts_packet_sync_aligner_tb.sv
